FILE: design/cfp_pkg.sv
`default_nettype none
package cfp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [7:0] CRC_POLY    = 8'h31;
   localparam logic [7:0] CRC_MSB     = 8'h80;

   localparam int PAYLOAD_BYTES = 4;
   localparam int FRAME_BITS    = 48;
   localparam int BIT_CNT_W     = $clog2(FRAME_BITS);
   localparam int STEP_W        = $clog2(PAYLOAD_BYTES + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = BIT_CNT_W'(FRAME_BITS - 1);
   localparam logic [STEP_W-1:0]    STEP_DONE    = STEP_W'(PAYLOAD_BYTES);

   // one byte through the msb-first crc register, eight shift steps
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_MSB) != 8'h00) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   // crc after the fixed header byte, start value zero
   localparam logic [7:0] HEADER_CRC = crc8_byte(8'h00, HEADER_BYTE);

   typedef struct packed {
      logic [31:0] payload;
      logic [7:0]  crc;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: design/cfp_front.sv
`default_nettype none
module cfp_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [31:0]                req_payload_word,
   input  wire cfp_pkg::queue_status_type  q_status,
   output logic                            q_push,
   output cfp_pkg::frame_type              q_frame
);

   logic                        busy_ff, busy_in;
   logic [cfp_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [31:0]                 word_ff, word_in;
   logic [7:0]                  crc_ff, crc_in;
   logic                        take;
   logic                        holding;

   assign holding   = (step_ff == cfp_pkg::STEP_DONE);
   assign q_push    = busy_ff && holding && !q_status.full;
   assign req_stall = busy_ff;
   assign take      = req_valid && !busy_ff;

   assign q_frame.payload = word_ff;
   assign q_frame.crc     = crc_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      word_in = word_ff;
      crc_in  = crc_ff;
      if (take) begin
         busy_in = 1'b1;
         step_in = '0;
         word_in = req_payload_word;
         crc_in  = cfp_pkg::HEADER_CRC;
      end else if (busy_ff && !holding) begin
         // one payload byte a cycle, word rotates back to its original order
         crc_in  = cfp_pkg::crc8_byte(crc_ff, word_ff[31:24]);
         word_in = {word_ff[23:0], word_ff[31:24]};
         step_in = step_ff + 1'b1;
      end else if (q_push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      word_ff <= word_in;
      crc_ff  <= crc_in;
   end

endmodule
`default_nettype wire

FILE: design/cfp_queue.sv
`default_nettype none
module cfp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire cfp_pkg::frame_type         push_frame,
   input  wire logic                       pop,
   output cfp_pkg::frame_type              pop_frame,
   output cfp_pkg::queue_status_type       status
);

   cfp_pkg::frame_type                  mem_ff [cfp_pkg::QUEUE_DEPTH];
   logic [cfp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cfp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cfp_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign status.full  = (count_ff == cfp_pkg::QUEUE_CNT_W'(cfp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_frame    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule
`default_nettype wire

FILE: design/cfp_back.sv
`default_nettype none
module cfp_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfp_pkg::queue_status_type  q_status,
   input  wire cfp_pkg::frame_type         q_frame,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_line_bit,
   output logic                            rsp_last_bit
);

   logic                                valid_ff, valid_in;
   logic [cfp_pkg::BIT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [cfp_pkg::FRAME_BITS-1:0]      shift_ff, shift_in;
   logic                                at_last;
   logic                                sent;

   assign at_last      = (cnt_ff == cfp_pkg::LAST_BIT_IDX);
   assign sent         = valid_ff && !rsp_stall;
   assign q_pop        = !q_status.empty && (!valid_ff || (sent && at_last));
   assign rsp_valid    = valid_ff;
   assign rsp_line_bit = shift_ff[cfp_pkg::FRAME_BITS-1];
   assign rsp_last_bit = at_last;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         cnt_in   = '0;
         shift_in = {cfp_pkg::HEADER_BYTE, q_frame.payload, q_frame.crc};
      end else if (sent) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            cnt_in   = cnt_ff + 1'b1;
            shift_in = {shift_ff[cfp_pkg::FRAME_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      shift_ff <= shift_in;
   end

endmodule
`default_nettype wire

FILE: design/crc8_packet_framer_serializer.sv
`default_nettype none
// Frames each 32-bit request as header 0xAA, the four payload bytes (bits 31..24 first)
// and a CRC-8 (poly 0x31, init 0, no reflection, no final xor) over those five bytes,
// then sends the 48 packet bits one per cycle while rsp_stall is low, msb first per byte,
// with rsp_last_bit high on the final bit. The front computes the CRC one byte a cycle
// and passes the frame through a two-entry queue, so while a frame waits in the queue
// packets follow each other with no idle bit, and the next request is taken while the
// current packet is still shifting out.
module crc8_packet_framer_serializer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_payload_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_line_bit,
   output logic             rsp_last_bit
);

   cfp_pkg::frame_type         push_frame;
   cfp_pkg::frame_type         pop_frame;
   cfp_pkg::queue_status_type  q_status;
   logic                       q_push;
   logic                       q_pop;

   cfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_word (req_payload_word),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_frame          (push_frame)
   );

   cfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .pop_frame  (pop_frame),
      .status     (q_status)
   );

   cfp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_frame      (pop_frame),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_line_bit (rsp_line_bit),
      .rsp_last_bit (rsp_last_bit)
   );

endmodule
`default_nettype wire
